### src/rrg_pkg.sv
// Package for the reference ramp generator: field widths, register indexes,
// profile phase codes and the configuration struct.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rrg_pkg;

	// Default fixed-point format of the reference
	localparam int RRG_REF_FRAC_BITS = 20;
	localparam int RRG_REF_WIDTH     = 24;

	// Configuration register widths
	localparam int CFG_STEP_W  = 17;
	localparam int CFG_TICK_W  = 20;
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 3;

	// Tick counter and phase code widths
	localparam int ELAPSED_W = 22;
	localparam int PHASE_W   = 3;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_STEP      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DECEL_STEP      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEST_ACCEL_STEP = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TEST_DECEL_STEP = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_POSITIVE_TICKS  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_TICKS      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_NEGATIVE_TICKS  = 3'd7;

	// Profile phase codes
	localparam logic [PHASE_W-1:0] PHASE_POSITIVE = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_ZERO_A   = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_NEGATIVE = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_ZERO_B   = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_NONE     = 3'd4;

	// Tick lengths reset value
	localparam logic [CFG_TICK_W-1:0] TICKS_RESET = 20'd1000;

	// Register file contents as seen by the datapath
	typedef struct packed {
		logic                  test_mode;
		logic [CFG_STEP_W-1:0] accel_step;
		logic [CFG_STEP_W-1:0] decel_step;
		logic [CFG_STEP_W-1:0] test_accel_step;
		logic [CFG_STEP_W-1:0] test_decel_step;
		logic [CFG_TICK_W-1:0] positive_ticks;
		logic [CFG_TICK_W-1:0] zero_ticks;
		logic [CFG_TICK_W-1:0] negative_ticks;
	} rrg_cfg_t;

endpackage

`default_nettype wire

### src/reference_ramp_generator_top.sv
// Top level of the reference ramp generator: stream handshake, input and
// result registers. Depends on rrg_pkg, rrg_cfg and rrg_core.
`timescale 1ns / 1ps
`default_nettype none

// Reference ramp generator. Each request on the slave stream is one tick
// carrying a set reference; each tick yields exactly one result on the
// master stream with the rate-limited reference and the test profile
// phase. One tick is accepted per clock cycle when the master side takes
// results; each result passes the input register, then the result register.
// The rate is set by the state loop: the stored output and the tick
// counter are updated together by one add, compare and clamp. The
// slave side keeps accepting while a result waits on the master side,
// until the input register is also full. Configuration writes take effect
// at the next clock and should be made only while no tick is in flight.

module reference_ramp_generator_top import rrg_pkg::*; #(
	parameter int REF_FRAC_BITS = RRG_REF_FRAC_BITS,
	parameter int REF_WIDTH     = RRG_REF_WIDTH,
	localparam int IN_W  = ((REF_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((REF_WIDTH + PHASE_W + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// slave stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_W-1:0]        s_tdata,  // set_reference
	// master stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_W-1:0]            m_tdata   // ramped_reference, profile_phase
);

	rrg_cfg_t cfg;

	logic                        valid_s1;
	logic signed [REF_WIDTH-1:0] ref_s1;
	logic                        adv_s1;
	logic                        core_en;
	logic signed [REF_WIDTH-1:0] core_ramp;
	logic [PHASE_W-1:0]          core_phase;
	logic                        out_valid_q;
	logic signed [REF_WIDTH-1:0] ramp_q;
	logic [PHASE_W-1:0]          phase_q;

	rrg_cfg #(
		.REF_FRAC_BITS(REF_FRAC_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: input register moves on when the result register is free
	assign adv_s1   = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign core_en  = valid_s1 && adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ref_s1 <= s_tdata[REF_WIDTH-1:0];
		end
	end

	rrg_core #(
		.REF_FRAC_BITS(REF_FRAC_BITS),
		.REF_WIDTH    (REF_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (core_en),
		.set_reference   (ref_s1),
		.cfg             (cfg),
		.ramped_reference(core_ramp),
		.profile_phase   (core_phase)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en) begin
			ramp_q  <= core_ramp;
			phase_q <= core_phase;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({phase_q, ramp_q});

endmodule

`default_nettype wire

### src/rrg_cfg.sv
// Configuration register file of the reference ramp generator.
// Depends on rrg_pkg for widths, register indexes and rrg_cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module rrg_cfg import rrg_pkg::*; #(
	parameter int REF_FRAC_BITS = RRG_REF_FRAC_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output rrg_cfg_t                    cfg
);

	// About one thousandth in the reference format, truncated to the register
	localparam longint ONE = longint'(1) << REF_FRAC_BITS;
	localparam logic [CFG_STEP_W-1:0] DEFAULT_STEP = CFG_STEP_W'((ONE + 500) / 1000);

	rrg_cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.test_mode       <= 1'b0;
			cfg_q.accel_step      <= DEFAULT_STEP;
			cfg_q.decel_step      <= DEFAULT_STEP;
			cfg_q.test_accel_step <= '0;
			cfg_q.test_decel_step <= '0;
			cfg_q.positive_ticks  <= TICKS_RESET;
			cfg_q.zero_ticks      <= TICKS_RESET;
			cfg_q.negative_ticks  <= TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEST_MODE:       cfg_q.test_mode       <= cfg_data[0];
				REG_ACCEL_STEP:      cfg_q.accel_step      <= cfg_data[CFG_STEP_W-1:0];
				REG_DECEL_STEP:      cfg_q.decel_step      <= cfg_data[CFG_STEP_W-1:0];
				REG_TEST_ACCEL_STEP: cfg_q.test_accel_step <= cfg_data[CFG_STEP_W-1:0];
				REG_TEST_DECEL_STEP: cfg_q.test_decel_step <= cfg_data[CFG_STEP_W-1:0];
				REG_POSITIVE_TICKS:  cfg_q.positive_ticks  <= cfg_data[CFG_TICK_W-1:0];
				REG_ZERO_TICKS:      cfg_q.zero_ticks      <= cfg_data[CFG_TICK_W-1:0];
				REG_NEGATIVE_TICKS:  cfg_q.negative_ticks  <= cfg_data[CFG_TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/rrg_core.sv
// Ramp datapath: target selection, test profile counter and the
// rate-limited, clamped move of the stored output. Depends on rrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrg_core import rrg_pkg::*; #(
	parameter int REF_FRAC_BITS = RRG_REF_FRAC_BITS,
	parameter int REF_WIDTH     = RRG_REF_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic signed [REF_WIDTH-1:0] set_reference,
	input  wire rrg_cfg_t                    cfg,
	output logic signed [REF_WIDTH-1:0]      ramped_reference,
	output logic [PHASE_W-1:0]               profile_phase
);

	// Substitute step for a zero normal step: about one tenth
	localparam longint ONE      = longint'(1) << REF_FRAC_BITS;
	localparam longint FALLBACK = (ONE + 5) / 10;
	localparam int FB_BITS  = $clog2(FALLBACK + 1);
	localparam int STEP_W   = (FB_BITS > CFG_STEP_W) ? FB_BITS : CFG_STEP_W;
	localparam int SUM_W    = ((REF_WIDTH > STEP_W) ? REF_WIDTH : STEP_W) + 2;
	localparam logic [STEP_W-1:0] FALLBACK_STEP = STEP_W'(FALLBACK);
	localparam logic signed [REF_WIDTH-1:0] REF_MAX = {1'b0, {(REF_WIDTH-1){1'b1}}};
	localparam logic signed [REF_WIDTH-1:0] REF_MIN = {1'b1, {(REF_WIDTH-1){1'b0}}};

	logic signed [REF_WIDTH-1:0] output_value_q;
	logic [ELAPSED_W-1:0]        elapsed_q;

	logic signed [REF_WIDTH-1:0] neg_ref;
	logic [ELAPSED_W-1:0]        b1, b2, b3, b4;
	logic [PHASE_W-1:0]          phase;
	logic signed [REF_WIDTH-1:0] tgt;
	logic [CFG_STEP_W-1:0]       gate;
	logic [STEP_W-1:0]           up, down, rise, fall;
	logic                        jumps;
	logic signed [SUM_W-1:0]     cur_x, tgt_x, rise_x, fall_x, sum_up, sum_dn;
	logic signed [REF_WIDTH-1:0] ramp_v;
	logic signed [REF_WIDTH-1:0] next_value;
	logic [ELAPSED_W-1:0]        next_elapsed;

	// Phase boundaries of the test profile
	always_comb begin
		b1 = ELAPSED_W'(cfg.positive_ticks);
		b2 = b1 + ELAPSED_W'(cfg.zero_ticks);
		b3 = b2 + ELAPSED_W'(cfg.negative_ticks);
		b4 = b3 + ELAPSED_W'(cfg.zero_ticks);
	end

	// Negated reference, most negative saturates to most positive
	assign neg_ref = (set_reference == REF_MIN) ? REF_MAX : -set_reference;

	// Phase, target and step selection
	always_comb begin
		phase = PHASE_NONE;
		tgt   = '0;
		gate  = cfg.test_decel_step;
		if (cfg.test_mode) begin
			if (elapsed_q < b1) begin
				phase = PHASE_POSITIVE;
				tgt   = set_reference;
				gate  = cfg.test_accel_step;
			end else if (elapsed_q < b2) begin
				phase = PHASE_ZERO_A;
			end else if (elapsed_q < b3) begin
				phase = PHASE_NEGATIVE;
				tgt   = neg_ref;
				gate  = cfg.test_accel_step;
			end else if (elapsed_q < b4) begin
				phase = PHASE_ZERO_B;
			end
			up    = STEP_W'(cfg.test_accel_step);
			down  = STEP_W'(cfg.test_decel_step);
			jumps = 1'b1;
		end else begin
			tgt   = set_reference;
			up    = (cfg.accel_step == '0) ? FALLBACK_STEP : STEP_W'(cfg.accel_step);
			down  = (cfg.decel_step == '0) ? FALLBACK_STEP : STEP_W'(cfg.decel_step);
			jumps = 1'b0;
		end
	end

	// Rate-limited move; accel and decel swap below zero
	always_comb begin
		rise   = output_value_q[REF_WIDTH-1] ? down : up;
		fall   = output_value_q[REF_WIDTH-1] ? up : down;
		cur_x  = SUM_W'(output_value_q);
		tgt_x  = SUM_W'(tgt);
		rise_x = signed'(SUM_W'(rise));
		fall_x = signed'(SUM_W'(fall));
		sum_up = cur_x + rise_x;
		sum_dn = cur_x - fall_x;
		ramp_v = output_value_q;
		if (tgt > output_value_q) begin
			if ((rise == '0 && jumps) || sum_up > tgt_x) begin
				ramp_v = tgt;
			end else begin
				ramp_v = sum_up[REF_WIDTH-1:0];
			end
		end else if (tgt < output_value_q) begin
			if ((fall == '0 && jumps) || sum_dn < tgt_x) begin
				ramp_v = tgt;
			end else begin
				ramp_v = sum_dn[REF_WIDTH-1:0];
			end
		end
	end

	// Next state: jump, ramp, or hold on the wrap tick
	always_comb begin
		next_value   = ramp_v;
		next_elapsed = elapsed_q;
		if (cfg.test_mode) begin
			if (phase == PHASE_NONE) begin
				next_value   = output_value_q;
				next_elapsed = '0;
			end else begin
				if (gate == '0) begin
					next_value = tgt;
				end
				next_elapsed = ELAPSED_W'(elapsed_q + 1'b1);
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_value_q <= '0;
			elapsed_q      <= '0;
		end else if (en) begin
			output_value_q <= next_value;
			elapsed_q      <= next_elapsed;
		end
	end

	assign ramped_reference = next_value;
	assign profile_phase    = phase;

endmodule

`default_nettype wire

### src/rrg_checker.sv
// Port-level checker for the reference ramp generator and its bind.
// Depends on rrg_pkg and reference_ramp_generator_top.
`timescale 1ns / 1ps
`default_nettype none

module rrg_checker import rrg_pkg::*; #(
	parameter int REF_WIDTH = RRG_REF_WIDTH,
	parameter int OUT_W     = ((REF_WIDTH + PHASE_W + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// No result is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A result is on offer after an accepted request passes the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted request produced no result");

	// Phase code stays within its defined codes
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[REF_WIDTH+PHASE_W-1:REF_WIDTH] <= PHASE_NONE)
		else $error("undefined profile phase code");

endmodule

bind reference_ramp_generator_top rrg_checker #(
	.REF_WIDTH(REF_WIDTH)
) u_rrg_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
